/* rtl/pgs_pkg.sv */
package pgs_pkg;

    localparam int VALUE_W    = 16;
    localparam int POS_W      = 12;
    localparam int LEN_W      = 13;
    localparam int MARGIN_W   = 5;
    localparam int MAX_LENGTH = 4096;
    localparam int MARGIN_MAX = 16;
    localparam int DATA_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = 2;
    localparam int QCNT_W     = QPTR_W + 1;

    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_MARGIN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROFILE_LENGTH = 2'd1;

    localparam logic [MARGIN_W-1:0] MARGIN_RESET = 5'd4;
    localparam logic [LEN_W-1:0]    LENGTH_RESET = 13'd4096;

    typedef struct packed {
        logic             edge_valid;
        logic [POS_W-1:0] edge_pos;
        logic             final_valid;
        logic [POS_W-1:0] final_pos;
        logic             none_found;
    } pgs_job_t;

endpackage

/* rtl/projection_gap_separator_unit.sv */
// an input beat's results are written into the job queue, then registered at the output
// throughput: one input beat per cycle while the job queue has room; each result is
//   one output beat, so an item with an edge and the profile end gives two, edge first
// a four-entry job queue between classifier and output stage absorbs stalls
// reset (rst_n low, asynchronous) clears all profile state and the queue,
//   edge_margin returns to 4 and profile_length to 4096
module projection_gap_separator_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [pgs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pgs_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [pgs_pkg::VALUE_W-1:0]      s_axis_tdata,  // profile_value
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [pgs_pkg::DATA_W-1:0]       m_axis_tdata,  // separator_position
    output logic                             m_axis_tlast,  // is_final
    output logic                             m_axis_tuser   // none_found
);
    import pgs_pkg::*;

    logic     push;
    logic     q_ready;
    logic     q_valid;
    logic     pop;
    pgs_job_t push_job;
    pgs_job_t head_job;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = q_ready;

    pgs_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .in_valid (s_axis_tvalid),
        .in_value (s_axis_tdata),
        .q_ready  (q_ready),
        .push     (push),
        .job      (push_job)
    );

    pgs_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_job(push_job),
        .ready   (q_ready),
        .pop     (pop),
        .valid   (q_valid),
        .head_job(head_job)
    );

    pgs_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_job    (head_job),
        .pop      (pop),
        .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready),
        .out_data (m_axis_tdata),
        .out_last (m_axis_tlast),
        .out_user (m_axis_tuser)
    );

endmodule

/* rtl/pgs_front.sv */
module pgs_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    input  logic [pgs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pgs_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_valid,
    input  logic [pgs_pkg::VALUE_W-1:0]       in_value,
    input  logic                              q_ready,
    output logic                              push,
    output pgs_pkg::pgs_job_t                 job
);
    import pgs_pkg::*;

    logic [MARGIN_W-1:0] edge_margin_reg;
    logic [LEN_W-1:0]    profile_length_reg;
    logic [POS_W-1:0]    sample_counter_reg, sample_counter_next;
    logic                older_zero_reg, older_zero_next;
    logic                newer_zero_reg, newer_zero_next;
    logic                first_emitted_reg, first_emitted_next;
    logic                pending_valid_reg, pending_valid_next;
    logic [POS_W-1:0]    pending_position_reg, pending_position_next;
    logic [POS_W-1:0]    latest_edge_reg, latest_edge_next;

    logic [MARGIN_W-1:0] k_c;
    logic [LEN_W-1:0]    len_c;
    logic [POS_W-1:0]    i_idx;
    logic                inner;
    logic                cur_zero;
    logic                is_last;
    logic                accept;
    logic [POS_W-1:0]    p_lo;
    logic [POS_W-1:0]    p_hi;
    logic [LEN_W-1:0]    hi_sum;
    logic [1:0]          edge_hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_margin_reg    <= MARGIN_RESET;
            profile_length_reg <= LENGTH_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_EDGE_MARGIN:    edge_margin_reg    <= cfg_data[MARGIN_W-1:0];
                CFG_PROFILE_LENGTH: profile_length_reg <= cfg_data[LEN_W-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        k_c = edge_margin_reg;
        if (edge_margin_reg == '0)
            k_c = MARGIN_W'(1);
        else if (edge_margin_reg > MARGIN_W'(MARGIN_MAX))
            k_c = MARGIN_W'(MARGIN_MAX);
        len_c = profile_length_reg;
        if (profile_length_reg == '0)
            len_c = LEN_W'(1);
        else if (profile_length_reg > LEN_W'(MAX_LENGTH))
            len_c = LEN_W'(MAX_LENGTH);
    end

    assign cur_zero = (in_value == '0);
    assign i_idx    = sample_counter_reg - POS_W'(1);
    assign hi_sum   = {1'b0, i_idx} + LEN_W'(k_c);
    assign p_lo     = i_idx - POS_W'(k_c);
    assign p_hi     = hi_sum[POS_W-1:0];
    assign inner    = (sample_counter_reg != '0) && (i_idx >= POS_W'(k_c))
                      && (hi_sum < len_c) && newer_zero_reg;
    assign edge_hit = {inner && !older_zero_reg, inner && !cur_zero};
    assign is_last  = ({1'b0, sample_counter_reg} + LEN_W'(1)) >= len_c;
    assign accept   = in_valid && q_ready;

    // edges taken in order: low side first, then high side
    always_comb
    begin
        logic [POS_W-1:0] p;
        logic [LEN_W-1:0] pair_sum;
        first_emitted_next    = first_emitted_reg;
        pending_valid_next    = pending_valid_reg;
        pending_position_next = pending_position_reg;
        latest_edge_next      = latest_edge_reg;
        job                   = '0;
        for (int e = 0; e < 2; e++)
        begin
            p        = (e == 0) ? p_lo : p_hi;
            pair_sum = {1'b0, pending_position_next} + {1'b0, p};
            if (edge_hit[e])
            begin
                latest_edge_next = p;
                if (!first_emitted_next)
                begin
                    first_emitted_next = 1'b1;
                    job.edge_valid     = 1'b1;
                    job.edge_pos       = p;
                end
                else if (!pending_valid_next)
                begin
                    pending_valid_next    = 1'b1;
                    pending_position_next = p;
                end
                else
                begin
                    pending_valid_next = 1'b0;
                    job.edge_valid     = 1'b1;
                    job.edge_pos       = pair_sum[LEN_W-1:1];
                end
            end
        end
        job.final_valid = is_last;
        job.final_pos   = first_emitted_next ? latest_edge_next : '0;
        job.none_found  = !first_emitted_next;

        older_zero_next     = newer_zero_reg;
        newer_zero_next     = cur_zero;
        sample_counter_next = sample_counter_reg + POS_W'(1);
        if (is_last)
        begin
            older_zero_next       = 1'b0;
            newer_zero_next       = 1'b0;
            sample_counter_next   = '0;
            first_emitted_next    = 1'b0;
            pending_valid_next    = 1'b0;
            pending_position_next = '0;
            latest_edge_next      = '0;
        end
    end

    assign push = accept && (job.edge_valid || job.final_valid);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_counter_reg   <= '0;
            older_zero_reg       <= 1'b0;
            newer_zero_reg       <= 1'b0;
            first_emitted_reg    <= 1'b0;
            pending_valid_reg    <= 1'b0;
            pending_position_reg <= '0;
            latest_edge_reg      <= '0;
        end
        else if (accept)
        begin
            sample_counter_reg   <= sample_counter_next;
            older_zero_reg       <= older_zero_next;
            newer_zero_reg       <= newer_zero_next;
            first_emitted_reg    <= first_emitted_next;
            pending_valid_reg    <= pending_valid_next;
            pending_position_reg <= pending_position_next;
            latest_edge_reg      <= latest_edge_next;
        end
    end

endmodule

/* rtl/pgs_queue.sv */
module pgs_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  pgs_pkg::pgs_job_t push_job,
    output logic              ready,
    input  logic              pop,
    output logic              valid,
    output pgs_pkg::pgs_job_t head_job
);
    import pgs_pkg::*;

    pgs_job_t          mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign ready    = count_reg != QCNT_W'(QDEPTH);
    assign valid    = count_reg != '0;
    assign head_job = mem_reg[rd_ptr_reg];
    assign do_push  = push && ready;
    assign do_pop   = pop && valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + QCNT_W'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - QCNT_W'(1);
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("queue count over depth");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_ptr_reg - rd_ptr_reg) == count_reg[QPTR_W-1:0])
        else $error("queue pointers disagree with count");

endmodule

/* rtl/pgs_back.sv */
module pgs_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_valid,
    input  pgs_pkg::pgs_job_t            q_job,
    output logic                         pop,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [pgs_pkg::DATA_W-1:0]   out_data,
    output logic                         out_last,
    output logic                         out_user
);
    import pgs_pkg::*;

    logic                out_valid_reg;
    logic [POS_W-1:0]    out_pos_reg;
    logic                out_last_reg;
    logic                out_user_reg;
    logic                phase_reg;
    logic                load;
    logic                take_edge;

    assign load      = !out_valid_reg || out_ready;
    assign take_edge = q_job.edge_valid && !phase_reg;
    assign pop       = load && q_valid && !(take_edge && q_job.final_valid);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= q_valid;
            if (q_valid)
                phase_reg <= take_edge && q_job.final_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && q_valid)
        begin
            if (take_edge)
            begin
                out_pos_reg  <= q_job.edge_pos;
                out_last_reg <= 1'b0;
                out_user_reg <= 1'b0;
            end
            else
            begin
                out_pos_reg  <= q_job.final_pos;
                out_last_reg <= 1'b1;
                out_user_reg <= q_job.none_found;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = DATA_W'(out_pos_reg);
    assign out_last  = out_last_reg;
    assign out_user  = out_user_reg;

    a_phase_head: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> q_valid)
        else $error("split job lost its head entry");

    a_none_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_user_reg |-> out_last_reg && out_pos_reg == '0)
        else $error("empty-profile beat not final or nonzero");

endmodule

/* test/tb.sv */
module tb;
    import pgs_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 2'd3;

    typedef struct packed {
        bit [POS_W-1:0] pos;
        bit             fin;
        bit             none;
    } sep_t;

    typedef struct packed {
        bit                  set_cfg;
        bit [CFG_DATA_W-1:0] margin_val;
        bit [CFG_DATA_W-1:0] length_val;
        bit [VALUE_W-1:0]    value;
        bit                  fixed;
        bit                  has_sep;
        sep_t                sep;
    } drow_t;

    localparam sep_t NO_SEP         = '0;
    localparam sep_t NONE_FOUND_SEP = '{pos: '0, fin: 1'b1, none: 1'b1};

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [VALUE_W-1:0]    s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [DATA_W-1:0]     m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  m_axis_tuser;

    projection_gap_separator_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    initial
    begin
        #80_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // separator predictor state
    bit [MARGIN_W-1:0] margin_reg;
    bit [LEN_W-1:0]    length_reg;
    bit [POS_W-1:0]    sample_idx;
    bit                older_zero;
    bit                newer_zero;
    bit                first_done;
    bit                pair_open;
    bit [POS_W-1:0]    open_pos;
    bit [POS_W-1:0]    last_edge;

    sep_t  step_seps[$];
    sep_t  expected_seps[$];
    drow_t directed_rows[$];
    sep_t  head_sep;
    int    mismatches;
    bit    in_steady;
    bit    out_steady;
    int    stall_left;

    function automatic void add_step_sep(sep_t s);
        step_seps.insert(step_seps.size(), s);
    endfunction

    function automatic void add_expected_sep(sep_t s);
        expected_seps.insert(expected_seps.size(), s);
    endfunction

    function automatic void add_row(drow_t row);
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    function automatic void clear_profile_state();
        sample_idx = '0;
        older_zero = 1'b0;
        newer_zero = 1'b0;
        first_done = 1'b0;
        pair_open  = 1'b0;
        open_pos   = '0;
        last_edge  = '0;
    endfunction

    function automatic void note_edge(int pos);
        int mean;
        last_edge = pos[POS_W-1:0];
        if (!first_done)
        begin
            first_done = 1'b1;
            add_step_sep('{pos: pos[POS_W-1:0], fin: 1'b0, none: 1'b0});
        end
        else if (!pair_open)
        begin
            pair_open = 1'b1;
            open_pos  = pos[POS_W-1:0];
        end
        else
        begin
            pair_open = 1'b0;
            mean = (int'(open_pos) + pos) >> 1;
            add_step_sep('{pos: mean[POS_W-1:0], fin: 1'b0, none: 1'b0});
        end
    endfunction

    // index j-1 is judged once value j is known
    function automatic void predict_separators(bit [VALUE_W-1:0] v);
        int  k;
        int  len;
        int  j;
        int  i;
        bit  cur_zero;
        k = int'(margin_reg);
        if (k < 1) k = 1;
        if (k > MARGIN_MAX) k = MARGIN_MAX;
        len = int'(length_reg);
        if (len < 1) len = 1;
        if (len > MAX_LENGTH) len = MAX_LENGTH;
        j = int'(sample_idx);
        cur_zero = (v == '0);
        step_seps.delete();
        if (j >= 1)
        begin
            i = j - 1;
            if (i >= k && i + k < len && newer_zero)
            begin
                if (!cur_zero) note_edge(i - k);
                if (!older_zero) note_edge(i + k);
            end
        end
        if (j + 1 >= len)
        begin
            if (first_done)
                add_step_sep('{pos: last_edge, fin: 1'b1, none: 1'b0});
            else
                add_step_sep(NONE_FOUND_SEP);
            clear_profile_state();
        end
        else
        begin
            older_zero = newer_zero;
            newer_zero = cur_zero;
            sample_idx = POS_W'(j + 1);
        end
    endfunction

    function automatic int idle_len(bit steady);
        int r;
        if (steady) return 0;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(3, 1);
        return $urandom_range(30, 5);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_seps.size() == 0)
            begin
                $error("separator beat with none expected: tdata %0d tlast %0b tuser %0b",
                       m_axis_tdata, m_axis_tlast, m_axis_tuser);
                mismatches++;
            end
            else
            begin
                head_sep = expected_seps.pop_front();
                if (m_axis_tdata !== {{(DATA_W-POS_W){1'b0}}, head_sep.pos})
                begin
                    $error("separator_position expected %0d actual %0d",
                           head_sep.pos, m_axis_tdata);
                    mismatches++;
                end
                if (m_axis_tlast !== head_sep.fin)
                begin
                    $error("is_final expected %0b actual %0b", head_sep.fin, m_axis_tlast);
                    mismatches++;
                end
                if (m_axis_tuser !== head_sep.none)
                begin
                    $error("none_found expected %0b actual %0b", head_sep.none, m_axis_tuser);
                    mismatches++;
                end
            end
        end
        if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else if (out_steady || !rst_n)
            m_axis_tready <= 1'b1;
        else
        begin
            stall_left = idle_len(1'b0);
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // lower the input and let every in-flight beat come out
    task automatic drain_block();
        s_axis_tvalid <= 1'b0;
        while (expected_seps.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input bit [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        if (idx == CFG_EDGE_MARGIN)
            margin_reg = data[MARGIN_W-1:0];
        else if (idx == CFG_PROFILE_LENGTH)
            length_reg = data;
    endtask

    task automatic set_config(input bit [CFG_DATA_W-1:0] margin_val,
                              input bit [CFG_DATA_W-1:0] length_val, input bit poke_spare);
        drain_block();
        if (poke_spare) cfg_write(CFG_SPARE_INDEX, CFG_DATA_W'($urandom));
        cfg_write(CFG_EDGE_MARGIN, margin_val);
        cfg_write(CFG_PROFILE_LENGTH, length_val);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_value(input bit [VALUE_W-1:0] v, input bit fixed, input bit has_sep,
                              input sep_t sep);
        int gap;
        gap = idle_len(in_steady);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        predict_separators(v);
        if (fixed)
        begin
            if (has_sep) add_expected_sep(sep);
        end
        else
            foreach (step_seps[n]) add_expected_sep(step_seps[n]);
    endtask

    // alternating runs of zero and nonzero columns, with some stray values
    task automatic send_gap_pattern(input int count);
        int               run;
        int               sent;
        bit               zero_run;
        bit [VALUE_W-1:0] v;
        sent = 0;
        zero_run = ($urandom_range(1) == 1);
        while (sent < count)
        begin
            run = ($urandom_range(7) == 0) ? $urandom_range(12, 5) : $urandom_range(4, 1);
            for (int n = 0; n < run && sent < count; n++)
            begin
                if ($urandom_range(19) == 0)
                    v = VALUE_W'($urandom);
                else if (zero_run)
                    v = '0;
                else
                begin
                    case ($urandom_range(3))
                        0: v = 16'h1 << $urandom_range(15);
                        1: v = 16'hFFFF;
                        default: v = VALUE_W'($urandom_range(65535, 1));
                    endcase
                end
                send_value(v, 1'b0, 1'b0, NO_SEP);
                sent++;
            end
            zero_run = !zero_run;
        end
    endtask

    initial
    begin
        int r;
        int margin_w;
        int length_w;
        int m_eff;
        int l_eff;
        int beats;
        int random_beats;

        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        mismatches    = 0;
        stall_left    = 0;
        in_steady     = 1'b0;
        out_steady    = 1'b0;
        margin_reg    = MARGIN_RESET;
        length_reg    = LENGTH_RESET;
        clear_profile_state();

        // reset defaults, then a length change mid-profile
        add_row('{1'b0, 13'd0, 13'd0, 16'hFFFF, 1'b1, 1'b0, NO_SEP});
        add_row('{1'b1, 13'd0, 13'd1, 16'h0000, 1'b1, 1'b1, NONE_FOUND_SEP});
        add_row('{1'b0, 13'd0, 13'd0, 16'hFFFF, 1'b1, 1'b1, NONE_FOUND_SEP});
        add_row('{1'b1, 13'd1, 13'd0, 16'h0001, 1'b1, 1'b1, NONE_FOUND_SEP});
        // isolated zeros, pairs close on the final beat
        add_row('{1'b1, 13'd1, 13'd5, 16'h8000, 1'b0, 1'b0, NO_SEP});
        add_row('{1'b0, 13'd0, 13'd0, 16'h0000, 1'b0, 1'b0, NO_SEP});
        add_row('{1'b0, 13'd0, 13'd0, 16'h0001, 1'b0, 1'b0, NO_SEP});
        add_row('{1'b0, 13'd0, 13'd0, 16'h0000, 1'b0, 1'b0, NO_SEP});
        add_row('{1'b0, 13'd0, 13'd0, 16'hFFFF, 1'b0, 1'b0, NO_SEP});
        // profile too short for any inner index
        add_row('{1'b1, 13'd3, 13'd6, 16'h0000, 1'b0, 1'b0, NO_SEP});
        add_row('{1'b0, 13'd0, 13'd0, 16'h0101, 1'b0, 1'b0, NO_SEP});
        add_row('{1'b0, 13'd0, 13'd0, 16'h0000, 1'b0, 1'b0, NO_SEP});
        add_row('{1'b0, 13'd0, 13'd0, 16'h1010, 1'b0, 1'b0, NO_SEP});
        add_row('{1'b0, 13'd0, 13'd0, 16'h0000, 1'b0, 1'b0, NO_SEP});
        add_row('{1'b0, 13'd0, 13'd0, 16'hFFFF, 1'b1, 1'b1, NONE_FOUND_SEP});
        // zero run with one-sided and two-sided edges
        add_row('{1'b1, 13'd2, 13'd8, 16'h0007, 1'b0, 1'b0, NO_SEP});
        add_row('{1'b0, 13'd0, 13'd0, 16'h0000, 1'b0, 1'b0, NO_SEP});
        add_row('{1'b0, 13'd0, 13'd0, 16'h0000, 1'b0, 1'b0, NO_SEP});
        add_row('{1'b0, 13'd0, 13'd0, 16'h7000, 1'b0, 1'b0, NO_SEP});
        add_row('{1'b0, 13'd0, 13'd0, 16'h0000, 1'b0, 1'b0, NO_SEP});
        add_row('{1'b0, 13'd0, 13'd0, 16'h0700, 1'b0, 1'b0, NO_SEP});
        add_row('{1'b0, 13'd0, 13'd0, 16'h0070, 1'b0, 1'b0, NO_SEP});
        add_row('{1'b0, 13'd0, 13'd0, 16'hFFFF, 1'b0, 1'b0, NO_SEP});

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[n])
        begin
            if (directed_rows[n].set_cfg)
                set_config(directed_rows[n].margin_val, directed_rows[n].length_val, 1'b0);
            send_value(directed_rows[n].value, directed_rows[n].fixed,
                       directed_rows[n].has_sep, directed_rows[n].sep);
        end

        // start of a full-size profile with the widest margin
        set_config(13'd31, 13'd8191, 1'b1);
        send_gap_pattern(40);

        random_beats = 0;
        while (random_beats < 220)
        begin
            r = $urandom_range(9);
            if (r < 4) margin_w = $urandom_range(4, 1);
            else if (r == 4) margin_w = 0;
            else if (r < 8) margin_w = $urandom_range(MARGIN_MAX, 5);
            else margin_w = $urandom_range(31, MARGIN_MAX + 1);
            m_eff = (margin_w < 1) ? 1 : (margin_w > MARGIN_MAX) ? MARGIN_MAX : margin_w;

            r = $urandom_range(9);
            if (r < 6) length_w = 2 * m_eff + $urandom_range(24, 1);
            else if (r == 6) length_w = $urandom_range(1);
            else if (r == 7) length_w = 2 * m_eff + $urandom_range(1);
            else length_w = $urandom_range(8191, MAX_LENGTH);
            l_eff = (length_w < 1) ? 1 : (length_w > MAX_LENGTH) ? MAX_LENGTH : length_w;

            beats = (l_eff < MAX_LENGTH) ? $urandom_range(2 * l_eff + 4, l_eff)
                                         : $urandom_range(40, 10);
            set_config(CFG_DATA_W'(margin_w), CFG_DATA_W'(length_w), $urandom_range(7) == 0);
            in_steady  = ($urandom_range(3) == 0);
            out_steady = ($urandom_range(3) == 0);
            send_gap_pattern(beats);
            random_beats += beats;
        end

        s_axis_tvalid <= 1'b0;
        while (expected_seps.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
